// ===== rtl/iir3_pkg.sv =====
`timescale 1ns / 1ps

package iir3_pkg;

  localparam int SampleWidthDef  = 16;
  localparam int CoefFracBitsDef = 20;
  localparam int GuardBitsDef    = 8;

  // coefficients carry 3 integer bits plus sign on top of the fraction
  localparam int CoefIntBits  = 4;
  localparam int NumCoef      = 7;
  localparam int CfgAddrWidth = 5;
  localparam int CfgDataWidth = 32;

  typedef enum logic [2:0] {
    IdxB0,
    IdxB1,
    IdxB2,
    IdxB3,
    IdxA1,
    IdxA2,
    IdxA3
  } coef_idx_e;

endpackage

// ===== rtl/iir3_if.sv =====
`timescale 1ns / 1ps

interface iir3_in_if #(
  parameter int SampleWidth = iir3_pkg::SampleWidthDef
);
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface iir3_out_if #(
  parameter int SampleWidth = iir3_pkg::SampleWidthDef
);
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// ===== rtl/iir3_cfg.sv =====
`timescale 1ns / 1ps

module iir3_cfg #(
  parameter int CoefFracBits = iir3_pkg::CoefFracBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [iir3_pkg::CfgAddrWidth-1:0]     paddr,
  input  logic [iir3_pkg::CfgDataWidth-1:0]     pwdata,
  output logic [iir3_pkg::CfgDataWidth-1:0]     prdata,
  output logic                                  pready,
  output logic [iir3_pkg::NumCoef-1:0][iir3_pkg::CoefIntBits+CoefFracBits-1:0] coef_o
);
  import iir3_pkg::*;

  localparam int CW = CoefIntBits + CoefFracBits;

  logic [NumCoef-1:0][CW-1:0] coef_q;
  logic [2:0]                 idx;
  logic                       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign coef_o = coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // pass-through: b0 = 1.0, everything else zero
      for (int i = 0; i < NumCoef; i++) begin
        coef_q[i] <= (i == int'(IdxB0)) ? (CW'(1) << CoefFracBits) : '0;
      end
    end else if (wr_en) begin
      for (int i = 0; i < NumCoef; i++) begin
        if (idx == 3'(i)) begin
          coef_q[i] <= pwdata[CW-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < NumCoef; i++) begin
      if (idx == 3'(i)) begin
        prdata = CfgDataWidth'($signed(coef_q[i]));
      end
    end
  end

endmodule

// ===== rtl/iir3_core.sv =====
`timescale 1ns / 1ps

module iir3_core #(
  parameter int SampleWidth  = iir3_pkg::SampleWidthDef,
  parameter int CoefFracBits = iir3_pkg::CoefFracBitsDef,
  parameter int GuardBits    = iir3_pkg::GuardBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [iir3_pkg::NumCoef-1:0][iir3_pkg::CoefIntBits+CoefFracBits-1:0] coef_i,
  iir3_in_if.sink    in_i,
  iir3_out_if.source out_o
);
  import iir3_pkg::*;

  localparam int SW = SampleWidth;
  localparam int F  = CoefFracBits;
  localparam int G  = GuardBits;
  localparam int CW = CoefIntBits + F;
  localparam int HW = SW + G;         // history width
  localparam int PW = CW + SW;        // feedforward product
  localparam int FW = CW + HW;        // feedback product
  localparam int AW = CW + HW + 2;    // accumulator, holds all seven terms exactly
  localparam int TW = AW - F;         // accumulator after dropping the fraction

  localparam logic signed [AW-1:0] RndAcc  = AW'(1) <<< (F - 1);
  localparam logic signed [HW:0]   RndHist = (HW+1)'(G > 0 ? (1 << (G - 1)) : 0);
  localparam logic signed [HW-1:0] HistMax = {1'b0, {(HW-1){1'b1}}};
  localparam logic signed [HW-1:0] HistMin = {1'b1, {(HW-1){1'b0}}};
  localparam logic signed [SW-1:0] SmpMax  = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SmpMin  = {1'b1, {(SW-1){1'b0}}};

  // handshake state
  logic in_vld_q, in_vld_d;
  logic out_vld_q, out_vld_d;
  logic adv;

  // payload and history
  logic signed [SW-1:0] x_q;
  logic signed [SW-1:0] xh_q [3];
  logic signed [HW-1:0] yh_q [3];
  logic signed [SW-1:0] y_q, y_d;
  logic                 clip_q, clip_d;

  // datapath
  logic signed [PW-1:0]  pf [4];
  logic signed [FW-1:0]  pb [3];
  logic signed [PW+1:0]  ff;
  logic signed [AW-1:0]  acc;
  logic signed [TW-1:0]  hf;
  logic [TW-HW:0]        hf_top;
  logic                  hist_ok;
  logic signed [HW-1:0]  h;
  logic signed [HW:0]    hr;
  logic signed [SW:0]    yr;
  logic                  smp_ok;

  assign adv         = in_vld_q & (~out_vld_q | out_o.ready);
  assign in_i.ready  = ~in_vld_q | adv;
  assign in_vld_d    = (in_i.valid & in_i.ready) | (in_vld_q & ~adv);
  assign out_vld_d   = adv | (out_vld_q & ~out_o.ready);

  assign pf[0] = $signed(coef_i[IdxB0]) * x_q;
  assign pf[1] = $signed(coef_i[IdxB1]) * xh_q[0];
  assign pf[2] = $signed(coef_i[IdxB2]) * xh_q[1];
  assign pf[3] = $signed(coef_i[IdxB3]) * xh_q[2];
  assign pb[0] = $signed(coef_i[IdxA1]) * yh_q[0];
  assign pb[1] = $signed(coef_i[IdxA2]) * yh_q[1];
  assign pb[2] = $signed(coef_i[IdxA3]) * yh_q[2];

  assign ff  = (PW+2)'(pf[0]) + (PW+2)'(pf[1]) + (PW+2)'(pf[2]) + (PW+2)'(pf[3]);
  assign acc = (AW'(ff) <<< G) - AW'(pb[0]) - AW'(pb[1]) - AW'(pb[2]) + RndAcc;
  assign hf  = acc[AW-1:F];

  // history clamp: the dropped top bits must all match the sign
  assign hf_top  = hf[TW-1:HW-1];
  assign hist_ok = (&hf_top) | ~(|hf_top);
  assign h       = hist_ok ? hf[HW-1:0] : (hf[TW-1] ? HistMin : HistMax);

  assign hr     = {h[HW-1], h} + RndHist;
  assign yr     = hr[HW:G];
  assign smp_ok = (yr[SW] == yr[SW-1]);

  always_comb begin
    y_d    = smp_ok ? yr[SW-1:0] : (yr[SW] ? SmpMin : SmpMax);
    clip_d = ~hist_ok | ~smp_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        xh_q[i] <= '0;
        yh_q[i] <= '0;
      end
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        xh_q[2] <= xh_q[1];
        xh_q[1] <= xh_q[0];
        xh_q[0] <= x_q;
        yh_q[2] <= yh_q[1];
        yh_q[1] <= yh_q[0];
        yh_q[0] <= h;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      x_q <= in_i.sample_in;
    end
    if (adv) begin
      y_q    <= y_d;
      clip_q <= clip_d;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.sample_out = y_q;
  assign out_o.clipped    = clip_q;

endmodule

// ===== rtl/third_order_iir_lowpass_top.sv =====
`timescale 1ns / 1ps
// Third-order direct form I IIR filter, one sample item in, one result item out.
// An item is held in the input register, and its result is then written to the result
// register, which holds it until the output side takes it.
// Throughput: one item per cycle while the output side takes results; the seven
// products, the sum and the feedback into the output history are all combinational.
// Reset: handshake state and both histories clear; coefficients return to pass-through.

module third_order_iir_lowpass_top #(
  parameter int SampleWidth  = iir3_pkg::SampleWidthDef,
  parameter int CoefFracBits = iir3_pkg::CoefFracBitsDef,
  parameter int GuardBits    = iir3_pkg::GuardBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [iir3_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [iir3_pkg::CfgDataWidth-1:0] pwdata,
  output logic [iir3_pkg::CfgDataWidth-1:0] prdata,
  output logic                              pready,
  iir3_in_if.sink                           in_i,
  iir3_out_if.source                        out_o
);
  import iir3_pkg::*;

  localparam int CW = CoefIntBits + CoefFracBits;
  localparam logic signed [SampleWidth-1:0] SmpMax = {1'b0, {(SampleWidth-1){1'b1}}};
  localparam logic signed [SampleWidth-1:0] SmpMin = {1'b1, {(SampleWidth-1){1'b0}}};

  logic [NumCoef-1:0][CW-1:0] coef;

  iir3_cfg #(
    .CoefFracBits(CoefFracBits)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .coef_o (coef)
  );

  iir3_core #(
    .SampleWidth (SampleWidth),
    .CoefFracBits(CoefFracBits),
    .GuardBits   (GuardBits)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .coef_i(coef),
    .in_i  (in_i),
    .out_o (out_o)
  );

`ifndef SYNTHESIS
  // item taken while the result register is stalled fills the input register,
  // so the next ready simply follows the output side
  a_fill_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && out_o.valid && !out_o.ready)
      |=> (in_i.ready == out_o.ready))
    else $error("input ready not tied to output side after fill");

  // any clamp, in the history or at the sample, leaves the sample at a limit
  a_clip_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.clipped)
      |-> (out_o.sample_out == SmpMax || out_o.sample_out == SmpMin))
    else $error("clipped item not at a saturation limit");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr[4:2] <= 3'(NumCoef - 1))
      |=> (!$stable(paddr) ||
           prdata == CfgDataWidth'($signed($past(pwdata[CW-1:0])))))
    else $error("coefficient readback mismatch");
`endif

endmodule

// ===== verif/third_order_iir_lowpass_top_tb.sv =====
`timescale 1ns / 1ps

module third_order_iir_lowpass_top_tb;
  import iir3_pkg::*;

  localparam int SampleWidth   = SampleWidthDef;
  localparam int CoefFracBits  = CoefFracBitsDef;
  localparam int GuardBits     = GuardBitsDef;
  localparam int CoefWidth     = CoefFracBits + CoefIntBits;
  localparam int HistWidth     = SampleWidth + GuardBits;
  localparam int ItemsPerPhase = 160;
  localparam int NumRandPhases = 8;
  localparam int LongHoldLen   = 300;
  localparam int WatchdogLimit = 2000;

  localparam logic [CoefWidth-1:0] CoefMax  = {1'b0, {(CoefWidth-1){1'b1}}};
  localparam logic [CoefWidth-1:0] CoefMin  = {1'b1, {(CoefWidth-1){1'b0}}};
  localparam logic [CoefWidth-1:0] UnitGain = CoefWidth'(1 << CoefFracBits);
  localparam logic [CoefWidth-1:0] HalfGain = CoefWidth'(1 << (CoefFracBits - 1));

  // Butterworth sets in Q3.20, order b0 b1 b2 b3 a1 a2 a3
  localparam logic [CoefWidth-1:0] ButterNarrow [NumCoef] = '{
    24'd18978, 24'd56935, 24'd56935, 24'd18978,
    -24'sd1845532, 24'd1240356, -24'sd291565
  };
  localparam logic [CoefWidth-1:0] ButterWide [NumCoef] = '{
    24'd103285, 24'd309959, 24'd309959, 24'd103285,
    -24'sd605238, 24'd442289, -24'sd59035
  };

  typedef struct packed {
    logic signed [SampleWidth-1:0] sample_out;
    logic                          clipped;
  } filt_out_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CfgAddrWidth-1:0] paddr;
  logic [CfgDataWidth-1:0] pwdata;
  logic [CfgDataWidth-1:0] prdata;
  logic                    pready;

  iir3_in_if  #(.SampleWidth(SampleWidth)) in_if ();
  iir3_out_if #(.SampleWidth(SampleWidth)) out_if ();

  third_order_iir_lowpass_top #(
    .SampleWidth (SampleWidth),
    .CoefFracBits(CoefFracBits),
    .GuardBits   (GuardBits)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #6 clk_i = ~clk_i;

  // filter state as the block should hold it
  logic signed [CoefWidth-1:0]   coef_q [NumCoef];
  logic signed [SampleWidth-1:0] x_hist [3];
  logic signed [HistWidth-1:0]   y_hist [3];

  logic [SampleWidth-1:0] samples_to_send [$];
  filt_out_t              filtered_q [$];
  filt_out_t              head_res;

  bit gaps_on;
  int send_gap;
  int recv_stall;
  int hold_left;
  int hold_asked;
  int hold_served;
  int quiet_cycles;
  int n_accepted;
  int n_results;
  int n_clipped;
  int n_settings;
  int fail_cnt;

  function automatic longint clamp(longint v, int w, inout logic clip);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clip = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clip = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic filt_out_t filter_sample(logic signed [SampleWidth-1:0] x0);
    longint    acc;
    longint    hist;
    longint    y;
    logic      clip;
    filt_out_t r;
    clip = 1'b0;
    acc = longint'(coef_q[IdxB0]) * longint'(x0);
    for (int i = 0; i < 3; i++)
      acc += longint'(coef_q[int'(IdxB1) + i]) * longint'(x_hist[i]);
    acc = acc <<< GuardBits;
    for (int i = 0; i < 3; i++)
      acc -= longint'(coef_q[int'(IdxA1) + i]) * longint'(y_hist[i]);
    // round half up into the guarded history, then again to the sample width
    acc += longint'(1) <<< (CoefFracBits - 1);
    hist = clamp(acc >>> CoefFracBits, HistWidth, clip);
    y = clamp((hist + (longint'(1) <<< (GuardBits - 1))) >>> GuardBits, SampleWidth, clip);
    x_hist[2] = x_hist[1];
    x_hist[1] = x_hist[0];
    x_hist[0] = x0;
    y_hist[2] = y_hist[1];
    y_hist[1] = y_hist[0];
    y_hist[0] = HistWidth'(hist);
    r.sample_out = SampleWidth'(y);
    r.clipped    = clip;
    return r;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [CoefWidth-1:0] coef_for(int setting, int idx);
    case (setting)
      0, 7: return ButterNarrow[idx];
      1: return ButterWide[idx];
      2: return CoefWidth'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      3: return CoefWidth'($urandom);
      4: return (idx < int'(IdxA1)) ? CoefWidth'($urandom) : '0;
      5: return $urandom_range(0, 1) ? CoefMax : CoefMin;
      default: begin
        if (idx == int'(IdxB0))
          return CoefWidth'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        if (idx == int'(IdxA1))
          return CoefWidth'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
        return '0;
      end
    endcase
  endfunction

  task automatic apb_write(input int idx, input logic [CfgDataWidth-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrWidth'(idx * 4);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // index past a3 is dropped by the block
    if (idx < NumCoef) coef_q[idx] = data[CoefWidth-1:0];
  endtask

  task automatic apb_check_read(input int idx);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CfgAddrWidth'(idx * 4);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata[CoefWidth-1:0] !== coef_q[idx]) begin
      $error("coef[%0d] readback: expected %0h, actual %0h", idx, coef_q[idx],
             prdata[CoefWidth-1:0]);
      fail_cnt++;
    end
  endtask

  task automatic load_coefs(input logic [CoefWidth-1:0] vals [NumCoef]);
    for (int i = 0; i < NumCoef; i++)
      apb_write(i, {{(CfgDataWidth-CoefWidth){vals[i][CoefWidth-1]}}, vals[i]});
    for (int i = 0; i < NumCoef; i++)
      apb_check_read(i);
    n_settings++;
  endtask

  task automatic queue_samples(input int count);
    int               left;
    int               run;
    int               shape;
    logic [SampleWidth-1:0] held;
    left = count;
    while (left > 0) begin
      run = $urandom_range(4, 32);
      if (run > left) run = left;
      shape = $urandom_range(0, 3);
      held = SampleWidth'($urandom);
      for (int k = 0; k < run; k++) begin
        case (shape)
          0: samples_to_send.push_back(SampleWidth'($urandom));
          1: samples_to_send.push_back(SampleWidth'(int'($urandom_range(0, 1023)) - 512));
          // full-scale square wave drives the histories into saturation
          2: samples_to_send.push_back(k[2] ? {1'b1, {(SampleWidth-1){1'b0}}}
                                            : {1'b0, {(SampleWidth-1){1'b1}}});
          default: samples_to_send.push_back(held);
        endcase
      end
      left -= run;
    end
  endtask

  task automatic drain();
    // checked between edges, once the driver's updates have settled
    while (samples_to_send.size() != 0 || in_if.valid || filtered_q.size() != 0)
      @(negedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.sample_in <= '0;
      send_gap        <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        filtered_q.push_back(filter_sample(in_if.sample_in));
        n_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          in_if.valid <= 1'b0;
          send_gap    <= send_gap - 1;
        end else if (samples_to_send.size() > 0) begin
          in_if.valid     <= 1'b1;
          in_if.sample_in <= samples_to_send.pop_front();
          send_gap        <= gaps_on ? gap_len() : 0;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_stall   <= 0;
      hold_left    <= 0;
      hold_served  <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (filtered_q.size() == 0) begin
          $error("result with no sample pending: sample_out=%0d clipped=%0b",
                 out_if.sample_out, out_if.clipped);
          fail_cnt++;
        end else begin
          head_res = filtered_q.pop_front();
          if (head_res.clipped) n_clipped++;
          if (out_if.sample_out !== head_res.sample_out) begin
            $error("sample_out: expected %0d, actual %0d", head_res.sample_out,
                   out_if.sample_out);
            fail_cnt++;
          end
          if (out_if.clipped !== head_res.clipped) begin
            $error("clipped: expected %0b, actual %0b", head_res.clipped, out_if.clipped);
            fail_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (hold_asked != hold_served) begin
        out_if.ready <= 1'b0;
        hold_left    <= LongHoldLen - 1;
        hold_served  <= hold_served + 1;
      end else if (recv_stall > 0) begin
        out_if.ready <= 1'b0;
        recv_stall   <= recv_stall - 1;
      end else if (gaps_on && $urandom_range(0, 99) < 15) begin
        out_if.ready <= 1'b0;
        recv_stall   <= gap_len();
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // progress watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CoefWidth-1:0] vals [NumCoef];
    int                   mark;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    out_if.ready    = 1'b0;
    gaps_on         = 1'b1;
    hold_asked      = 0;
    quiet_cycles    = 0;
    for (int i = 0; i < NumCoef; i++) coef_q[i] = '0;
    coef_q[IdxB0] = UnitGain;
    for (int i = 0; i < 3; i++) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset coefficients: straight pass-through, field extremes
    samples_to_send.push_back(16'h0000);
    samples_to_send.push_back(16'h7FFF);
    samples_to_send.push_back(16'h8000);
    samples_to_send.push_back(16'h0001);
    samples_to_send.push_back(16'hFFFF);
    samples_to_send.push_back(16'h5555);
    samples_to_send.push_back(16'hAAAA);
    drain();
    n_settings++;

    // write past the last register must leave pass-through intact
    apb_write(NumCoef, 32'hFFC0_0000);
    samples_to_send.push_back(16'h1234);
    samples_to_send.push_back(16'hEDCC);
    drain();

    // extreme, unstable coefficients: both saturation stages
    load_coefs('{CoefMax, CoefMin, CoefMax, CoefMin, CoefMax, CoefMin, CoefMax});
    samples_to_send.push_back(16'h7FFF);
    samples_to_send.push_back(16'h8000);
    samples_to_send.push_back(16'h7FFF);
    samples_to_send.push_back(16'h8000);
    samples_to_send.push_back(16'h0000);
    samples_to_send.push_back(16'h0000);
    drain();

    // gain 0.5 puts odd samples exactly on the half, checks round half up
    load_coefs('{HalfGain, '0, '0, '0, '0, '0, '0});
    samples_to_send.push_back(16'h0001);
    samples_to_send.push_back(16'hFFFF);
    samples_to_send.push_back(16'h0003);
    samples_to_send.push_back(16'hFFFD);
    drain();

    for (int p = 0; p < NumRandPhases; p++) begin
      for (int i = 0; i < NumCoef; i++) vals[i] = coef_for(p, i);
      load_coefs(vals);
      gaps_on = (p != 3);
      mark = n_accepted;
      queue_samples(ItemsPerPhase);
      if (p == 1) begin
        // stall the receiver long enough to back up the input side
        while (n_accepted < mark + 20) @(posedge clk_i);
        hold_asked++;
      end
      drain();
    end

    repeat (4) @(posedge clk_i);
    $display("Filtered %0d samples under %0d coefficient settings, %0d results clipped.",
             n_accepted, n_settings, n_clipped);
    $display("Included pass-through, extreme and Butterworth sets, bursts and long stalls.");
    if (fail_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
